FILE: rtl/core/mcr_pkg.sv
package mcr_pkg;

    localparam int COORD_BITS = 12;

    localparam int POS_W   = 13;
    localparam int RAD_W   = 12;
    localparam int LW_W    = 8;
    localparam int HW_W    = LW_W - 1;
    localparam int OFF_W   = 9;
    localparam int XY_W    = 14;
    localparam int DEC_W   = 18;
    localparam int PT_W    = 15;
    localparam int DIM_W   = 13;
    localparam int COLOR_W = 24;

    localparam int PTS_PER_STEP = 8;
    localparam int K_W          = $clog2(PTS_PER_STEP);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [DIM_W-1:0]   ROWS_RST  = DIM_W'(480);
    localparam logic [DIM_W-1:0]   COLS_RST  = DIM_W'(640);
    localparam logic [COLOR_W-1:0] COLOR_RST = COLOR_W'(24'hFFFFFF);

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        REG_IMAGE_ROWS = 2'd0,
        REG_IMAGE_COLS = 2'd1,
        REG_DRAW_COLOR = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] cen_row;
        logic signed [POS_W-1:0] cen_col;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic                    done;
    } job_t;

endpackage

FILE: rtl/core/mcr_queue.sv
module mcr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  mcr_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output mcr_pkg::job_t rd_data,
    output logic          rd_valid
);
    import mcr_pkg::*;

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1))
        begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/mcr_front.sv
module mcr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  logic                              func,
    input  logic signed [mcr_pkg::POS_W-1:0]  center_x,
    input  logic signed [mcr_pkg::POS_W-1:0]  center_y,
    input  logic        [mcr_pkg::RAD_W-1:0]  radius,
    input  logic        [mcr_pkg::LW_W-1:0]   line_width,
    output logic                              job_push,
    output mcr_pkg::job_t                     job
);
    import mcr_pkg::*;

    localparam logic signed [DEC_W-1:0] DEC_INIT    = DEC_W'(3);
    localparam logic signed [DEC_W-1:0] DEC_POS_INC = DEC_W'(10);
    localparam logic signed [DEC_W-1:0] DEC_NEG_INC = DEC_W'(6);
    localparam logic signed [XY_W-1:0]  XY_ONE      = XY_W'(1);
    localparam logic signed [OFF_W-1:0] OFF_ONE     = OFF_W'(1);

    logic                     active_reg, active_next;
    logic signed [POS_W-1:0]  cr_reg, cr_next;
    logic signed [POS_W-1:0]  cc_reg, cc_next;
    logic        [RAD_W-1:0]  base_reg, base_next;
    logic        [HW_W-1:0]   hw_reg, hw_next;
    logic signed [OFF_W-1:0]  off_reg, off_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [DEC_W-1:0]  d_reg, d_next;

    logic                     is_start;
    logic        [HW_W-1:0]   hw_in;
    logic signed [XY_W-1:0]   rad_s, hw_s, off_w, r_start, r_ring;
    logic signed [XY_W-1:0]   diff, x_inc, y_dec, y_n;
    logic signed [OFF_W-1:0]  off_inc;
    logic signed [DEC_W-1:0]  d_pos, d_neg, d_n;
    logic                     ring_end, more_rings, done_flag;

    function automatic logic signed [DEC_W-1:0] ring_dec(input logic signed [XY_W-1:0] r);
        logic signed [DEC_W-1:0] re;
        re = DEC_W'(r);
        return DEC_INIT - (re <<< 1);
    endfunction

    always_comb
    begin
        is_start = take && (func_t'(func) == FUNC_START);
        job_push = take && (func_t'(func) == FUNC_STEP) && active_reg;

        hw_in   = line_width[LW_W-1:1];
        rad_s   = signed'(XY_W'(radius));
        hw_s    = signed'(XY_W'(hw_in));
        off_w   = (rad_s < hw_s) ? -rad_s : -hw_s;
        r_start = rad_s + off_w;

        off_inc = off_reg + OFF_ONE;
        r_ring  = signed'(XY_W'(base_reg)) + XY_W'(off_inc);

        diff  = x_reg - y_reg;
        d_pos = d_reg + (DEC_W'(diff) <<< 2) + DEC_POS_INC;
        d_neg = d_reg + (DEC_W'(x_reg) <<< 2) + DEC_NEG_INC;
        x_inc = x_reg + XY_ONE;
        y_dec = y_reg - XY_ONE;
        y_n   = d_reg[DEC_W-1] ? y_reg : y_dec;
        d_n   = d_reg[DEC_W-1] ? d_neg : d_pos;

        ring_end   = (x_inc > y_n);
        more_rings = (off_reg < signed'(OFF_W'(hw_reg)));
        done_flag  = ring_end && !more_rings;

        active_next = active_reg;
        cr_next     = cr_reg;
        cc_next     = cc_reg;
        base_next   = base_reg;
        hw_next     = hw_reg;
        off_next    = off_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;

        if (is_start)
        begin
            active_next = 1'b1;
            cr_next     = center_y;
            cc_next     = center_x;
            base_next   = radius;
            hw_next     = hw_in;
            off_next    = OFF_W'(off_w);
            x_next      = '0;
            y_next      = r_start;
            d_next      = ring_dec(r_start);
        end
        else if (job_push)
        begin
            if (!ring_end)
            begin
                x_next = x_inc;
                y_next = y_n;
                d_next = d_n;
            end
            else if (more_rings)
            begin
                off_next = off_inc;
                x_next   = '0;
                y_next   = r_ring;
                d_next   = ring_dec(r_ring);
            end
            else
            begin
                active_next = 1'b0;
            end
        end

        job.cen_row = cr_reg;
        job.cen_col = cc_reg;
        job.x       = x_reg;
        job.y       = y_reg;
        job.done    = done_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cr_reg   <= cr_next;
        cc_reg   <= cc_next;
        base_reg <= base_next;
        hw_reg   <= hw_next;
        off_reg  <= off_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        d_reg    <= d_next;
    end

    a_push_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> active_reg)
        else $error("step request queued while no circle is active");

    a_done_ends_circle: assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && job.done) |=> !active_reg)
        else $error("circle still active after final ring");

    a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (off_reg <= signed'(OFF_W'(hw_reg))))
        else $error("ring offset beyond half width");

endmodule

FILE: rtl/core/mcr_back.sv
module mcr_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_valid,
    input  mcr_pkg::job_t                     job,
    output logic                              job_pop,
    input  logic [mcr_pkg::DIM_W-1:0]         image_rows,
    input  logic [mcr_pkg::DIM_W-1:0]         image_cols,
    input  logic [mcr_pkg::COLOR_W-1:0]       draw_color,
    output logic                              empty,
    input  logic                              pop,
    output logic [mcr_pkg::COORD_BITS-1:0]    pixel_row,
    output logic [mcr_pkg::COORD_BITS-1:0]    pixel_col,
    output logic [mcr_pkg::COLOR_W-1:0]       pixel_color,
    output logic                              last_of_step,
    output logic                              circle_done
);
    import mcr_pkg::*;

    localparam int LIM_W = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
    localparam int CMP_W = ((LIM_W > PT_W) ? LIM_W : PT_W) + 1;
    localparam logic [LIM_W-1:0] CAP     = LIM_W'(1) << COORD_BITS;
    localparam logic [K_W-1:0]   LAST_PT = K_W'(PTS_PER_STEP - 1);

    logic [K_W-1:0]        k_reg, k_next;
    logic                  ov_reg, ov_next;
    logic [COORD_BITS-1:0] row_reg, col_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic                  last_reg, done_reg;

    logic                  emit, swap, is_last;
    logic signed [PT_W-1:0] rterm, cterm, row_v, col_v;

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [PT_W-1:0] v,
        input logic        [DIM_W-1:0] size
    );
        logic        [LIM_W-1:0] lim;
        logic        [LIM_W-1:0] maxv;
        logic signed [CMP_W-1:0] vv;
        logic signed [CMP_W-1:0] mm;
        lim = LIM_W'(size);
        if (lim == '0)
        begin
            lim = LIM_W'(1);
        end
        if (lim > CAP)
        begin
            lim = CAP;
        end
        maxv = lim - LIM_W'(1);
        vv   = CMP_W'(v);
        mm   = signed'(CMP_W'(maxv));
        if (vv < 0)
        begin
            return '0;
        end
        if (vv > mm)
        begin
            return maxv[COORD_BITS-1:0];
        end
        return vv[COORD_BITS-1:0];
    endfunction

    always_comb
    begin
        emit    = job_valid && (!ov_reg || pop);
        is_last = (k_reg == LAST_PT);
        job_pop = emit && is_last;

        // octants 0..3 put y on the row, 4..7 put x on the row
        swap  = k_reg[2];
        rterm = swap ? PT_W'(job.x) : PT_W'(job.y);
        cterm = swap ? PT_W'(job.y) : PT_W'(job.x);
        row_v = PT_W'(job.cen_row) + (k_reg[0] ? -rterm : rterm);
        col_v = PT_W'(job.cen_col) + (k_reg[1] ? -cterm : cterm);

        k_next = k_reg;
        if (emit)
        begin
            k_next = is_last ? '0 : k_reg + K_W'(1);
        end

        ov_next = ov_reg;
        if (emit)
        begin
            ov_next = 1'b1;
        end
        else if (pop)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            k_reg  <= k_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            row_reg   <= clamp_coord(row_v, image_rows);
            col_reg   <= clamp_coord(col_v, image_cols);
            color_reg <= draw_color;
            last_reg  <= is_last;
            done_reg  <= is_last && job.done;
        end
    end

    assign empty        = !ov_reg;
    assign pixel_row    = row_reg;
    assign pixel_col    = col_reg;
    assign pixel_color  = color_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && done_reg) |-> last_reg)
        else $error("circle done flagged on a point other than the eighth");

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != '0) |-> (job_valid && $stable(job)))
        else $error("step request changed while its points were being drawn");

    a_drop_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(ov_reg) |-> $past(pop))
        else $error("point dropped without being taken");

endmodule

FILE: rtl/core/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer. A start request (func 0) latches center, radius and line width
// and produces no points; each step request (func 1) produces eight mirrored points of the
// current ring, clamped to the image, with last_of_step on the eighth and circle_done on the
// eighth point of the final step of the final ring. Steps while no circle is active are taken
// and dropped. Rings run from radius - line_width/2 to radius + line_width/2, skipping
// negative radii. The front takes one request per cycle, unless the queue is full, into a
// two-entry step queue; the point emitter drains one point per cycle while its output
// register is empty or popped, so the sustained rate is set by the emitter. A taken step is
// queued before the emitter registers its first point. Write the configuration registers
// (image_rows at 0x0, image_cols at 0x4, draw_color at 0x8) only while the block is idle.
module midpoint_circle_rasterizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mcr_pkg::ADDR_W-1:0]        paddr,
    input  logic [mcr_pkg::DATA_W-1:0]        pwdata,
    output logic [mcr_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic                              func,
    input  logic signed [mcr_pkg::POS_W-1:0]  center_x,
    input  logic signed [mcr_pkg::POS_W-1:0]  center_y,
    input  logic        [mcr_pkg::RAD_W-1:0]  radius,
    input  logic        [mcr_pkg::LW_W-1:0]   line_width,
    output logic                              empty,
    input  logic                              pop,
    output logic [mcr_pkg::COORD_BITS-1:0]    pixel_row,
    output logic [mcr_pkg::COORD_BITS-1:0]    pixel_col,
    output logic [mcr_pkg::COLOR_W-1:0]       pixel_color,
    output logic                              last_of_step,
    output logic                              circle_done
);
    import mcr_pkg::*;

    logic [DIM_W-1:0]   rows_reg, rows_next;
    logic [DIM_W-1:0]   cols_reg, cols_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    logic take;
    logic job_push, job_pop, q_full, q_valid;
    job_t job_in, job_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        color_next = color_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_IMAGE_ROWS: rows_next  = pwdata[DIM_W-1:0];
                REG_IMAGE_COLS: cols_next  = pwdata[DIM_W-1:0];
                REG_DRAW_COLOR: color_next = pwdata[COLOR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_IMAGE_ROWS: prdata = DATA_W'(rows_reg);
            REG_IMAGE_COLS: prdata = DATA_W'(cols_reg);
            REG_DRAW_COLOR: prdata = DATA_W'(color_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= ROWS_RST;
            cols_reg  <= COLS_RST;
            color_reg <= COLOR_RST;
        end
        else
        begin
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            color_reg <= color_next;
        end
    end

    assign full = q_full;
    assign take = push && !q_full;

    mcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .func       (func),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .line_width (line_width),
        .job_push   (job_push),
        .job        (job_in)
    );

    mcr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_data  (job_in),
        .full     (q_full),
        .rd_en    (job_pop),
        .rd_data  (job_out),
        .rd_valid (q_valid)
    );

    mcr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_valid),
        .job          (job_out),
        .job_pop      (job_pop),
        .image_rows   (rows_reg),
        .image_cols   (cols_reg),
        .draw_color   (color_reg),
        .empty        (empty),
        .pop          (pop),
        .pixel_row    (pixel_row),
        .pixel_col    (pixel_col),
        .pixel_color  (pixel_color),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule
